@@ hdl/c3f_pkg.sv @@
// Shared types and constants of the 3x3 convolution filter.
// No dependencies; imported by c3f_mac, conv3x3_image_filter and the testbench.
package c3f_pkg;

    // Fixed field and register widths
    localparam int PIX_W   = 8;
    localparam int LW_W    = 12;
    localparam int FH_W    = 16;
    localparam int KROW_W  = 48;
    localparam int SH_W    = 4;
    localparam int APB_DW  = 64;
    localparam int APB_AW  = 6;
    localparam int REGIX_W = 3;

    // Register map, one 64-bit slot per register
    typedef enum logic [REGIX_W-1:0] {
        REG_LINE_WIDTH   = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_KROW_TOP     = 3'd2,
        REG_KROW_MIDDLE  = 3'd3,
        REG_KROW_BOTTOM  = 3'd4,
        REG_RESULT_SHIFT = 3'd5
    } t_reg_idx;

    localparam logic [LW_W-1:0]   LINE_WIDTH_RST   = 12'd640;
    localparam logic [FH_W-1:0]   FRAME_HEIGHT_RST = 16'd480;
    localparam logic [KROW_W-1:0] KROW_TOP_RST     = 48'h0;
    localparam logic [KROW_W-1:0] KROW_MIDDLE_RST  = 48'h1000000;
    localparam logic [KROW_W-1:0] KROW_BOTTOM_RST  = 48'h0;
    localparam logic [SH_W-1:0]   SHIFT_RST        = 4'd8;

    // 3x3 window, row-major, entry 0 is top left
    typedef logic [8:0][PIX_W-1:0] t_win;

    // Three kernel rows, index 0 is the top row
    typedef logic [2:0][KROW_W-1:0] t_krows;

    // Position tags that travel with a result
    typedef struct packed {
        logic line_end;
        logic frame_end;
    } t_tag;

    // One result item
    typedef struct packed {
        logic [PIX_W-1:0] filtered_pixel;
        logic             saturated;
        logic             line_end;
        logic             frame_end;
    } t_res;

endpackage

@@ hdl/c3f_mac.sv @@
// Multiply-accumulate, shift and clamp pipeline of the 3x3 filter.
// Depends on c3f_pkg; instantiated by conv3x3_image_filter.
module c3f_mac #(
    parameter int COEF_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_vld,
    input  c3f_pkg::t_tag                   i_tag,
    input  c3f_pkg::t_win                   i_win,
    input  c3f_pkg::t_krows                 i_krows,
    input  logic [c3f_pkg::SH_W-1:0]        i_shift,
    output logic                            o_vld,
    output c3f_pkg::t_res                   o_res
);
    import c3f_pkg::*;

    localparam int PW = COEF_BITS + 9;          // one product
    localparam int RW = PW + 2;                 // sum of three
    localparam int SW = PW + 4;                 // sum of nine
    localparam int KW = (3 * COEF_BITS > KROW_W) ? 3 * COEF_BITS : KROW_W;

    logic signed [COEF_BITS-1:0] coef [9];
    logic signed [PW-1:0]        r_prod [9];
    logic signed [RW-1:0]        r_row [3];
    logic signed [SW-1:0]        r_sum;
    logic signed [SW-1:0]        shifted;
    logic                        r_a_vld, r_b_vld, r_c_vld;
    t_tag                        r_a_tag, r_b_tag, r_c_tag;
    logic [KW-1:0]               krow_ext [3];

    // Coefficient k of a row sits at bits k*COEF_BITS; bits past the register read as zero
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            krow_ext[i] = KW'(i_krows[i]);
            for (int j = 0; j < 3; j++) begin
                coef[i*3+j] = $signed(krow_ext[i][j*COEF_BITS +: COEF_BITS]);
            end
        end
    end

    // Stage A: nine products, pixel taken as unsigned
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 9; k++) begin
                r_prod[k] <= PW'($signed({1'b0, i_win[k]})) * PW'(coef[k]);
            end
        end
    end

    // Stage B: row sums
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_row[i] <= RW'(r_prod[i*3]) + RW'(r_prod[i*3+1]) + RW'(r_prod[i*3+2]);
            end
        end
    end

    // Stage C: total
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= SW'(r_row[0]) + SW'(r_row[1]) + SW'(r_row[2]);
        end
    end

    // Valid and tags along the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_tag <= i_tag;
            r_b_tag <= r_a_tag;
            r_c_tag <= r_b_tag;
        end
    end

    // Floor shift, then clamp to 0..255
    assign shifted = r_sum >>> i_shift;

    always_comb begin
        o_res.line_end  = r_c_tag.line_end;
        o_res.frame_end = r_c_tag.frame_end;
        if (shifted < 0) begin
            o_res.filtered_pixel = '0;
            o_res.saturated      = 1'b1;
        end else if (shifted > $signed(SW'(255))) begin
            o_res.filtered_pixel = '1;
            o_res.saturated      = 1'b1;
        end else begin
            o_res.filtered_pixel = shifted[PIX_W-1:0];
            o_res.saturated      = 1'b0;
        end
    end

    assign o_vld = r_c_vld;

endmodule

@@ hdl/conv3x3_image_filter.sv @@
// Top level of the 3x3 convolution filter: APB registers, line memory, window, output skid.
// Depends on c3f_pkg and c3f_mac.
//
//   Channel   Direction  Handshake                  Payload
//   pixel in  in         i_pix_valid / o_pix_ready  i_pixel, i_frame_start
//   result    out        o_res_valid / i_res_ready  o_filtered_pixel, o_saturated,
//                                                   o_line_end, o_frame_end
//   config    in         APB, pready tied high      paddr, pwdata, prdata (8-byte slots)
//
// One pixel per cycle while the skid register is empty. A result passes the window,
// three multiply-add stages and the output register before o_res_valid rises; the line
// memory read shares the accepting edge. Both line stores share one 16-bit memory, read
// and written once per cycle; a read of the column written at the same edge is served
// by a forwarding register.
// Reset is synchronous; the line memory is not cleared.
// When a result waits and another arrives, it lands in a skid register and the whole
// pipeline holds until the skid empties; o_pix_ready is low only then.
module conv3x3_image_filter #(
    parameter int MAX_LINE_WIDTH = 2048,
    parameter int COEF_BITS      = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // pixel input
    input  logic                          i_pix_valid,
    output logic                          o_pix_ready,
    input  logic [c3f_pkg::PIX_W-1:0]     i_pixel,
    input  logic                          i_frame_start,
    // result output
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output logic [c3f_pkg::PIX_W-1:0]     o_filtered_pixel,
    output logic                          o_saturated,
    output logic                          o_line_end,
    output logic                          o_frame_end,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [c3f_pkg::APB_AW-1:0]    paddr,
    input  logic [c3f_pkg::APB_DW-1:0]    pwdata,
    output logic [c3f_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import c3f_pkg::*;

    localparam int CW = $clog2(MAX_LINE_WIDTH);        // column index
    localparam int WW = $clog2(MAX_LINE_WIDTH + 1);    // effective width

    // Configuration registers
    logic [LW_W-1:0]   r_line_width;
    logic [FH_W-1:0]   r_frame_height;
    t_krows            r_krows;
    logic [SH_W-1:0]   r_shift;
    t_reg_idx          reg_idx;
    logic              cfg_wr;

    // Position and pipeline
    logic [CW-1:0]     r_col;
    logic [FH_W-1:0]   r_row;
    logic [WW-1:0]     eff_w;
    logic [FH_W-1:0]   eff_h;
    logic [CW-1:0]     col_a, col_b;
    logic [FH_W-1:0]   row_a, row_b, row_b_inc;
    logic [WW-1:0]     col_b_ext, col_n;
    logic              en, accept;

    logic              r_s1_vld, r_s1_emit;
    logic [CW-1:0]     r_s1_col;
    logic [PIX_W-1:0]  r_s1_px;
    t_tag              r_s1_tag;
    logic [2*PIX_W-1:0] r_line_mem [MAX_LINE_WIDTH];
    logic [2*PIX_W-1:0] r_mem_q, r_fwd_data, rd;
    logic              r_fwd_hit;
    logic [PIX_W-1:0]  top_px, mid_px;

    t_win              r_win;
    logic              r_s2_vld;
    t_tag              r_s2_tag;

    logic              mac_vld;
    t_res              mac_res;

    // Output register and skid
    logic              r_out_vld, r_skid_vld;
    t_res              r_out, r_skid;
    logic              take, deliver;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[APB_AW-1:3]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= LINE_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_krows[0]     <= KROW_TOP_RST;
            r_krows[1]     <= KROW_MIDDLE_RST;
            r_krows[2]     <= KROW_BOTTOM_RST;
            r_shift        <= SHIFT_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_LINE_WIDTH:   r_line_width   <= pwdata[LW_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[FH_W-1:0];
                REG_KROW_TOP:     r_krows[0]     <= pwdata[KROW_W-1:0];
                REG_KROW_MIDDLE:  r_krows[1]     <= pwdata[KROW_W-1:0];
                REG_KROW_BOTTOM:  r_krows[2]     <= pwdata[KROW_W-1:0];
                REG_RESULT_SHIFT: r_shift        <= pwdata[SH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_LINE_WIDTH:   prdata = APB_DW'(r_line_width);
            REG_FRAME_HEIGHT: prdata = APB_DW'(r_frame_height);
            REG_KROW_TOP:     prdata = APB_DW'(r_krows[0]);
            REG_KROW_MIDDLE:  prdata = APB_DW'(r_krows[1]);
            REG_KROW_BOTTOM:  prdata = APB_DW'(r_krows[2]);
            REG_RESULT_SHIFT: prdata = APB_DW'(r_shift);
            default:          prdata = '0;
        endcase
    end

    // ---------------- frame geometry ----------------
    always_comb begin
        if (r_line_width < LW_W'(3)) begin
            eff_w = WW'(3);
        end else if (32'(r_line_width) > 32'(MAX_LINE_WIDTH)) begin
            eff_w = WW'(MAX_LINE_WIDTH);
        end else begin
            eff_w = WW'(r_line_width);
        end
        eff_h = (r_frame_height < FH_W'(3)) ? FH_W'(3) : r_frame_height;
    end

    // Position of the incoming pixel: frame start, then wrap for a shrunk size
    always_comb begin
        col_a = i_frame_start ? '0 : r_col;
        row_a = i_frame_start ? '0 : r_row;
        if (WW'(col_a) >= eff_w) begin
            col_b = '0;
            row_b = row_a + FH_W'(1);
        end else begin
            col_b = col_a;
            row_b = row_a;
        end
        if (row_b >= eff_h) begin
            row_b = '0;
        end
        col_b_ext = WW'(col_b);
        col_n     = col_b_ext + WW'(1);
        row_b_inc = row_b + FH_W'(1);
    end

    assign en          = !r_skid_vld;
    assign o_pix_ready = en;
    assign accept      = i_pix_valid && o_pix_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (col_n >= eff_w) begin
                r_col <= '0;
                r_row <= (row_b_inc >= eff_h) ? '0 : row_b_inc;
            end else begin
                r_col <= CW'(col_n);
                r_row <= row_b;
            end
        end
    end

    // ---------------- stage 1: line memory read ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_col           <= col_b;
            r_s1_px            <= i_pixel;
            r_s1_emit          <= (row_b >= FH_W'(2)) && (col_b_ext >= WW'(2));
            r_s1_tag.line_end  <= (col_b_ext == eff_w - WW'(1));
            r_s1_tag.frame_end <= (col_b_ext == eff_w - WW'(1)) &&
                                  (row_b == eff_h - FH_W'(1));
        end
    end

    // Entry is {line two above, line one above}; same column written last cycle is forwarded
    assign rd     = r_fwd_hit ? r_fwd_data : r_mem_q;
    assign top_px = rd[2*PIX_W-1:PIX_W];
    assign mid_px = rd[PIX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mem_q <= r_line_mem[col_b];
            if (r_s1_vld) begin
                r_line_mem[r_s1_col] <= {mid_px, r_s1_px};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (en) begin
            r_fwd_hit <= r_s1_vld && (col_b == r_s1_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fwd_data <= {mid_px, r_s1_px};
        end
    end

    // ---------------- stage 2: window shift ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (en && r_s1_vld) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i*3]   <= r_win[i*3+1];
                r_win[i*3+1] <= r_win[i*3+2];
            end
            r_win[2] <= top_px;
            r_win[5] <= mid_px;
            r_win[8] <= r_s1_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (en) begin
            r_s2_vld <= r_s1_vld && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_tag <= r_s1_tag;
        end
    end

    // ---------------- multiply-add, shift, clamp ----------------
    c3f_mac #(
        .COEF_BITS (COEF_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_s2_vld),
        .i_tag   (r_s2_tag),
        .i_win   (r_win),
        .i_krows (r_krows),
        .i_shift (r_shift),
        .o_vld   (mac_vld),
        .o_res   (mac_res)
    );

    // ---------------- output register and skid ----------------
    assign take    = r_out_vld && i_res_ready;
    assign deliver = en && mac_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (take) begin
            if (r_skid_vld) begin
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= deliver;
            end
        end else if (!r_out_vld) begin
            r_out_vld <= deliver;
        end else if (deliver) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && r_skid_vld) begin
            r_out <= r_skid;
        end else if ((take || !r_out_vld) && deliver) begin
            r_out <= mac_res;
        end
        if (!take && r_out_vld && deliver) begin
            r_skid <= mac_res;
        end
    end

    assign o_res_valid      = r_out_vld;
    assign o_filtered_pixel = r_out.filtered_pixel;
    assign o_saturated      = r_out.saturated;
    assign o_line_end       = r_out.line_end;
    assign o_frame_end      = r_out.frame_end;

    // ---------------- checks ----------------
    // skid only ever holds a second result behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid holds a result while output register is empty");

    // a written line entry reads back what was written (entries of the first lines carry X)
    a_mem_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_s1_vld) |=> (r_line_mem[$past(r_s1_col)] === $past({mid_px, r_s1_px})))
        else $error("line memory write lost");

    // an accepted pixel always enters stage 1
    a_accept_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_vld)
        else $error("accepted pixel missing in stage 1");

    // last result of the frame is also last of its line
    a_frame_end_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_frame_end) |-> o_line_end)
        else $error("frame end without line end");

endmodule

@@ tb/tb_conv3x3_image_filter.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of conv3x3_image_filter: directed, then random, then directed frames.
// Depends on c3f_pkg and the conv3x3_image_filter RTL; holds its own filter predictor.
module tb_conv3x3_image_filter;
    import c3f_pkg::*;

    localparam int MAX_W        = 2048;
    localparam int COEF_W       = 16;
    localparam int CLK_HALF     = 10;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 1150;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_REPORTS  = 10;
    localparam int WIDE_W       = 120;

    logic             i_clk;
    logic             i_rst_n = 1'b0;
    logic             i_pix_valid = 1'b0;
    logic             o_pix_ready;
    logic [PIX_W-1:0] i_pixel = '0;
    logic             i_frame_start = 1'b0;
    logic             o_res_valid;
    logic             i_res_ready = 1'b0;
    logic [PIX_W-1:0] o_filtered_pixel;
    logic             o_saturated;
    logic             o_line_end;
    logic             o_frame_end;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    conv3x3_image_filter #(
        .MAX_LINE_WIDTH (MAX_W),
        .COEF_BITS      (COEF_W)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_pix_valid      (i_pix_valid),
        .o_pix_ready      (o_pix_ready),
        .i_pixel          (i_pixel),
        .i_frame_start    (i_frame_start),
        .o_res_valid      (o_res_valid),
        .i_res_ready      (i_res_ready),
        .o_filtered_pixel (o_filtered_pixel),
        .o_saturated      (o_saturated),
        .o_line_end       (o_line_end),
        .o_frame_end      (o_frame_end),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // Predictor copy of the registers, reset values from the package
    logic [LW_W-1:0] cfg_width  = LINE_WIDTH_RST;
    logic [FH_W-1:0] cfg_height = FRAME_HEIGHT_RST;
    t_krows          cfg_krows  = {KROW_BOTTOM_RST, KROW_MIDDLE_RST, KROW_TOP_RST};
    logic [SH_W-1:0] cfg_shift  = SHIFT_RST;

    // Predictor copy of the line stores, window and position
    logic [PIX_W-1:0] upper_line [MAX_W];
    logic [PIX_W-1:0] lower_line [MAX_W];
    logic [PIX_W-1:0] win_px [9];
    int               col_pos = 0;
    int               row_pos = 0;

    t_res expected_pixels[$];

    int error_count   = 0;
    int cycle_count   = 0;
    int items_sent    = 0;
    bit idle_en       = 1'b1;
    int hold_requests = 0;
    int hold_taken    = 0;
    int hold_left     = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_taken != hold_requests) begin
            hold_taken  <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            i_res_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_res_ready <= 1'b0;
        end else begin
            i_res_ready <= !(idle_en && ($urandom_range(0, 99) < 21));
        end
    end

    // Result checker: each transfer against the oldest expected pixel
    always @(posedge i_clk) begin : check_results
        t_res want;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (expected_pixels.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected result pix=%0d sat=%0b le=%0b fe=%0b",
                             o_filtered_pixel, o_saturated, o_line_end, o_frame_end);
            end else begin
                want = expected_pixels.pop_front();
                if (o_filtered_pixel !== want.filtered_pixel ||
                    o_saturated !== want.saturated ||
                    o_line_end !== want.line_end ||
                    o_frame_end !== want.frame_end) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("mismatch pix/sat/le/fe exp %0d/%0b/%0b/%0b got %0d/%0b/%0b/%0b",
                                 want.filtered_pixel, want.saturated, want.line_end,
                                 want.frame_end, o_filtered_pixel, o_saturated,
                                 o_line_end, o_frame_end);
                end
            end
        end
    end

    // Signed coefficient k of a kernel row, leftmost in the low bits
    function automatic longint kernel_coef(input logic [KROW_W-1:0] krow, input int k);
        logic signed [COEF_W-1:0] raw;
        raw = krow[k*COEF_W +: COEF_W];
        return longint'(raw);
    endfunction

    // Advance the predictor by one pixel; queue the filtered pixel if a window completes
    task automatic predict_filtered_pixel(input logic [PIX_W-1:0] px, input logic fs);
        int               w;
        int               h;
        int               c;
        int               r;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        longint           acc;
        longint           scaled;
        t_res             res;
        w = (cfg_width < 3) ? 3 : ((cfg_width > MAX_W) ? MAX_W : int'(cfg_width));
        h = (cfg_height < 3) ? 3 : int'(cfg_height);
        if (fs) begin
            col_pos = 0;
            row_pos = 0;
        end
        // position may be out of range after a size change
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h)
            row_pos = 0;
        c = col_pos;
        r = row_pos;

        top = upper_line[c];
        mid = lower_line[c];
        upper_line[c] = mid;
        lower_line[c] = px;
        for (int i = 0; i < 3; i++) begin
            win_px[i*3]   = win_px[i*3+1];
            win_px[i*3+1] = win_px[i*3+2];
        end
        win_px[2] = top;
        win_px[5] = mid;
        win_px[8] = px;

        if (r >= 2 && c >= 2) begin
            acc = 0;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    acc += longint'(win_px[i*3+j]) * kernel_coef(cfg_krows[i], j);
            scaled = acc >>> cfg_shift;
            res.saturated      = (scaled < 0) || (scaled > 255);
            res.filtered_pixel = (scaled < 0) ? 8'd0 : ((scaled > 255) ? 8'd255 : scaled[7:0]);
            res.line_end       = (c == w - 1);
            res.frame_end      = (c == w - 1) && (r == h - 1);
            expected_pixels.push_back(res);
        end

        col_pos = c + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h)
                row_pos = 0;
        end
    endtask

    // One pixel transfer, with random idle cycles before it
    task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs);
        while (idle_en && ($urandom_range(0, 99) < 21)) begin
            i_pix_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_pixel       <= px;
        i_frame_start <= fs;
        i_pix_valid   <= 1'b1;
        @(posedge i_clk);
        while (!o_pix_ready)
            @(posedge i_clk);
        predict_filtered_pixel(px, fs);
        items_sent++;
    endtask

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_pixels(input int n, input logic first_fs);
        for (int i = 0; i < n; i++)
            send_pixel(rand_pixel(), first_fs && (i == 0));
    endtask

    // Lower valid, wait for every expected pixel, then let the pipeline settle
    task automatic wait_idle();
        i_pix_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup cycle, access cycle
    task automatic write_reg(input t_reg_idx idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_LINE_WIDTH:   cfg_width    = value[LW_W-1:0];
            REG_FRAME_HEIGHT: cfg_height   = value[FH_W-1:0];
            REG_KROW_TOP:     cfg_krows[0] = value[KROW_W-1:0];
            REG_KROW_MIDDLE:  cfg_krows[1] = value[KROW_W-1:0];
            REG_KROW_BOTTOM:  cfg_krows[2] = value[KROW_W-1:0];
            REG_RESULT_SHIFT: cfg_shift    = value[SH_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input int w, input int h,
                             input logic [KROW_W-1:0] k_top, input logic [KROW_W-1:0] k_mid,
                             input logic [KROW_W-1:0] k_bot, input int sh);
        write_reg(REG_LINE_WIDTH, APB_DW'(w));
        write_reg(REG_FRAME_HEIGHT, APB_DW'(h));
        write_reg(REG_KROW_TOP, APB_DW'(k_top));
        write_reg(REG_KROW_MIDDLE, APB_DW'(k_mid));
        write_reg(REG_KROW_BOTTOM, APB_DW'(k_bot));
        write_reg(REG_RESULT_SHIFT, APB_DW'(sh));
    endtask

    // Mostly coefficients near +-1.0, sometimes the extremes
    function automatic logic [COEF_W-1:0] rand_coef();
        logic [COEF_W-1:0] v;
        int                t;
        case ($urandom_range(0, 9))
            0: v = 16'h7FFF;
            1: v = 16'h8000;
            2: v = 16'h0000;
            3: v = COEF_W'($urandom);
            default: begin
                t = int'($urandom_range(0, 640)) - 320;
                v = t[COEF_W-1:0];
            end
        endcase
        return v;
    endfunction

    function automatic logic [KROW_W-1:0] rand_krow();
        return {rand_coef(), rand_coef(), rand_coef()};
    endfunction

    // Only size registers written: reset kernel is identity with shift 8
    task automatic test_reset_kernel();
        logic [PIX_W-1:0] frame_a [9];
        logic [PIX_W-1:0] frame_b [9];
        frame_a = '{8'd0, 8'd255, 8'd17, 8'd128, 8'd255, 8'd0, 8'd1, 8'd254, 8'd200};
        frame_b = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255};
        write_reg(REG_LINE_WIDTH, APB_DW'(3));
        write_reg(REG_FRAME_HEIGHT, APB_DW'(3));
        foreach (frame_a[i])
            send_pixel(frame_a[i], i == 0);
        // next frame follows without a frame start: position wraps
        foreach (frame_b[i])
            send_pixel(frame_b[i], 1'b0);
        wait_idle();
    endtask

    // Left column max positive, right column max negative: clamp at both ends
    task automatic test_saturation();
        logic [KROW_W-1:0] edge_row;
        edge_row = {16'h8000, 16'h0000, 16'h7FFF};
        configure(5, 3, edge_row, edge_row, edge_row, 0);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 5; c++)
                send_pixel((c == 2) ? 8'd255 : 8'd0, (r == 0) && (c == 0));
        wait_idle();
    endtask

    // Sizes below 3 act as 3; a frame start mid-frame drops the partial frame
    task automatic test_size_clamp_restart();
        configure(1, 2, rand_krow(), rand_krow(), rand_krow(), 8);
        send_pixels(4, 1'b1);
        send_pixels(9, 1'b1);
        wait_idle();
        configure(2, 0, rand_krow(), rand_krow(), rand_krow(), 7);
        send_pixels(9, 1'b1);
        wait_idle();
    endtask

    // Width and height shrink while the position is inside the frame
    task automatic test_resize_midframe();
        configure(6, 6, rand_krow(), rand_krow(), rand_krow(), 8);
        send_pixels(2 * 6 + 4, 1'b1);
        wait_idle();
        // column 4 is beyond the new width: wraps to the next line
        write_reg(REG_LINE_WIDTH, APB_DW'(4));
        send_pixels(4, 1'b0);
        wait_idle();
        // row 4 is beyond the new height: wraps to row 0
        write_reg(REG_FRAME_HEIGHT, APB_DW'(4));
        send_pixels(16, 1'b0);
        wait_idle();
    endtask

    // Random settings; mostly whole frames, some cut short, some noisy frame starts
    task automatic test_random_frames();
        int start;
        int w;
        int h;
        int sh;
        int ew;
        int eh;
        int nframes;
        int mode;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            wait_idle();
            idle_en = ($urandom_range(0, 4) != 0);
            case ($urandom_range(0, 9))
                0:       w = $urandom_range(0, 2);
                1:       w = $urandom_range(11, 40);
                default: w = $urandom_range(3, 10);
            endcase
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            case ($urandom_range(0, 9))
                0:       sh = 0;
                1:       sh = 15;
                2:       sh = $urandom_range(0, 15);
                default: sh = $urandom_range(6, 10);
            endcase
            configure(w, h, rand_krow(), rand_krow(), rand_krow(), sh);
            ew = (w < 3) ? 3 : w;
            eh = (h < 3) ? 3 : h;
            nframes = $urandom_range(2, 5);
            for (int f = 0; f < nframes; f++) begin
                // a new setting always begins with a frame start
                mode = (f == 0) ? 9 : $urandom_range(0, 9);
                case (mode)
                    0: send_pixels($urandom_range(1, ew * eh - 1), 1'b1);
                    1: begin
                        repeat ($urandom_range(1, ew * eh))
                            send_pixel(rand_pixel(), $urandom_range(0, 15) == 0);
                    end
                    2:       send_pixels(ew * eh, 1'b0);
                    default: send_pixels(ew * eh, 1'b1);
                endcase
            end
        end
        wait_idle();
        idle_en = 1'b1;
    endtask

    // Receiver holds off while pixels keep coming: the block must stall its input
    task automatic test_output_backpressure();
        idle_en = 1'b0;
        configure(5, 40, rand_krow(), rand_krow(), rand_krow(), 8);
        hold_requests++;
        send_pixels(5 * 40, 1'b1);
        wait_idle();
        idle_en = 1'b1;
    endtask

    // A wide line, then register maxima (width clamps to the widest line, no window yet)
    task automatic test_widest_line();
        configure(WIDE_W, 3, rand_krow(), rand_krow(), rand_krow(), 8);
        send_pixels(3 * WIDE_W, 1'b1);
        wait_idle();
        configure(4095, 65535, rand_krow(), rand_krow(), rand_krow(), 9);
        send_pixels(64, 1'b1);
        wait_idle();
    endtask

    initial begin
        for (int i = 0; i < MAX_W; i++) begin
            upper_line[i] = '0;
            lower_line[i] = '0;
        end
        foreach (win_px[i])
            win_px[i] = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_kernel();
        test_saturation();
        test_size_clamp_restart();
        test_resize_midframe();
        test_random_frames();
        test_output_backpressure();
        test_widest_line();

        wait_idle();
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
